// ===== hw/rtl/pooled_free_list_allocator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Allocator assertion macros
// Shared concurrent assertion forms for the allocator's port checker.
// ----------------------------------------------------------------------------
`ifndef POOLED_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`define POOLED_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFLA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pfla_pkg.sv =====
// ----------------------------------------------------------------------------
// Allocator package
// Field widths, beat layout, codes and controller states of the allocator.
// ----------------------------------------------------------------------------
package pfla_pkg;

  localparam int INDEX_W   = 12;
  localparam int LINK_W    = 13;
  localparam int OFFSET_W  = 18;
  localparam int CAP_W     = 13;
  localparam int WORDS_W   = 7;
  localparam int INDEX_SPACE = 4096;

  localparam logic [LINK_W-1:0]  NULL_LINK      = 13'h1000;
  localparam logic [WORDS_W-1:0] MAX_ELEM_WORDS = 7'd64;
  localparam logic [WORDS_W-1:0] MIN_ELEM_WORDS = 7'd1;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic STATUS_DONE      = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 48;
  localparam int GRANT_LSB  = 0;
  localparam int OFFSET_LSB = GRANT_LSB + INDEX_W;
  localparam int STATUS_LSB = OFFSET_LSB + OFFSET_W;
  localparam int CAP_LSB    = STATUS_LSB + 1;
  localparam int M_USED_W   = CAP_LSB + CAP_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_GROW
  } state_t;

endpackage

// ===== hw/rtl/pfla_ram.sv =====
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfla_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/pooled_free_list_allocator_unit.sv =====
// Timing: a free, or an allocate that finds no room for a new pool, registers its result
// at acceptance; an allocate from a non-empty list passes through ST_POP (one link-memory
// read) and then the result register, and an allocate that adds a pool passes through
// ST_GROW while the new links are written one per cycle. One item is in flight at a time;
// an item is taken only once the previous result leaves.
// Reset clears the free list to empty, drops all pools and sets elem_words to 1;
// the link memory is not cleared.
// ----------------------------------------------------------------------------
// Pooled free-list allocator
// Fixed-size element allocator with a LIFO free list held in a link memory.
// ----------------------------------------------------------------------------
module pooled_free_list_allocator_unit
  import pfla_pkg::*;
#(
  parameter int ELEMS_PER_POOL = 128,
  parameter int MAX_POOLS      = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  // APB configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // Request stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // [11:0] element_index
  input  logic [0:0]           s_tuser,  // [0] action
  // Result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata   // [11:0] granted_index, [29:12] word_offset,
                                         // [30] status, [43:31] capacity
);

  localparam int CW = (ELEMS_PER_POOL > 1) ? $clog2(ELEMS_PER_POOL) : 1;
  localparam int PW = $clog2(MAX_POOLS + 1);
  localparam logic [CAP_W:0]   EPP_EXT   = (CAP_W + 1)'(ELEMS_PER_POOL);
  localparam logic [CAP_W:0]   SPACE_EXT = (CAP_W + 1)'(INDEX_SPACE);
  localparam logic [CAP_W-1:0] EPP_CAP   = CAP_W'(ELEMS_PER_POOL);
  localparam logic [CW-1:0]    CNT_LAST  = CW'(ELEMS_PER_POOL - 1);
  localparam logic [PW-1:0]    POOL_MAX  = PW'(MAX_POOLS);

  state_t state;
  state_t state_next;

  logic [WORDS_W-1:0] elem_words;
  logic [LINK_W-1:0]  free_head;
  logic [LINK_W-1:0]  free_head_next;
  logic [PW-1:0]      pools_in_use;
  logic [PW-1:0]      pools_in_use_next;
  logic [CAP_W-1:0]   capacity;
  logic [CAP_W-1:0]   capacity_next;
  logic [CW-1:0]      grow_cnt;
  logic [CW-1:0]      grow_cnt_next;

  logic [INDEX_W-1:0]  out_granted;
  logic [OFFSET_W-1:0] out_offset;
  logic                out_status;
  logic [CAP_W-1:0]    out_capacity;

  logic                res_load;
  logic [INDEX_W-1:0]  res_granted;
  logic                res_status;
  logic [WORDS_W-1:0]  words_eff;

  logic               ram_we;
  logic [INDEX_W-1:0] ram_waddr;
  logic [LINK_W-1:0]  ram_wdata;
  logic [LINK_W-1:0]  ram_rdata;

  logic               in_fire;
  logic               action;
  logic [INDEX_W-1:0] element_index;
  logic               head_null;
  logic               pool_ok;
  logic               grow_last;
  logic [CAP_W-1:0]   grow_elem;

  assign pready  = 1'b1;
  assign prdata  = {{(32 - WORDS_W){1'b0}}, elem_words};

  assign s_tready      = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign in_fire       = s_tvalid && s_tready;
  assign action        = s_tuser[0];
  assign element_index = s_tdata[INDEX_W-1:0];
  assign head_null     = (free_head == NULL_LINK);
  assign pool_ok       = (pools_in_use < POOL_MAX) &&
                         ({1'b0, capacity} + EPP_EXT <= SPACE_EXT);
  assign grow_last     = (grow_cnt == CNT_LAST);
  assign grow_elem     = capacity + CAP_W'(grow_cnt);

  assign m_tdata = {{(M_TDATA_W - M_USED_W){1'b0}}, out_capacity, out_status,
                    out_offset, out_granted};

  always_comb begin
    if (elem_words == '0) begin
      words_eff = MIN_ELEM_WORDS;
    end else if (elem_words > MAX_ELEM_WORDS) begin
      words_eff = MAX_ELEM_WORDS;
    end else begin
      words_eff = elem_words;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && action == ACT_ALLOC) begin
          if (!head_null) begin
            state_next = ST_POP;
          end else if (pool_ok) begin
            state_next = ST_GROW;
          end
        end
      end
      ST_POP: begin
        state_next = ST_IDLE;
      end
      ST_GROW: begin
        if (grow_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_we            = 1'b0;
    ram_waddr         = '0;
    ram_wdata         = '0;
    free_head_next    = free_head;
    pools_in_use_next = pools_in_use;
    capacity_next     = capacity;
    grow_cnt_next     = grow_cnt;
    res_load          = 1'b0;
    res_granted       = '0;
    res_status        = STATUS_DONE;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (action == ACT_FREE) begin
            res_load = 1'b1;
            if ({1'b0, element_index} < capacity) begin
              ram_we         = 1'b1;
              ram_waddr      = element_index;
              ram_wdata      = free_head;
              free_head_next = {1'b0, element_index};
            end
          end else if (head_null && !pool_ok) begin
            res_load   = 1'b1;
            res_status = STATUS_EXHAUSTED;
          end
        end
      end
      ST_POP: begin
        res_load       = 1'b1;
        res_granted    = free_head[INDEX_W-1:0];
        free_head_next = ram_rdata;
      end
      ST_GROW: begin
        ram_we    = 1'b1;
        ram_waddr = grow_elem[INDEX_W-1:0];
        ram_wdata = grow_last ? NULL_LINK : grow_elem + 1'b1;
        if (grow_last) begin
          grow_cnt_next     = '0;
          res_load          = 1'b1;
          res_granted       = capacity[INDEX_W-1:0];
          free_head_next    = (ELEMS_PER_POOL > 1) ? capacity + 1'b1 : NULL_LINK;
          capacity_next     = capacity + EPP_CAP;
          pools_in_use_next = pools_in_use + 1'b1;
        end else begin
          grow_cnt_next = grow_cnt + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  pfla_ram #(
    .WIDTH (LINK_W),
    .DEPTH (INDEX_SPACE)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (free_head[INDEX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      elem_words   <= MIN_ELEM_WORDS;
      free_head    <= NULL_LINK;
      pools_in_use <= '0;
      capacity     <= '0;
      grow_cnt     <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state        <= state_next;
      free_head    <= free_head_next;
      pools_in_use <= pools_in_use_next;
      capacity     <= capacity_next;
      grow_cnt     <= grow_cnt_next;
      if (psel && penable && pwrite && pready) begin
        elem_words <= pwdata[WORDS_W-1:0];
      end
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_granted  <= res_granted;
      out_offset   <= OFFSET_W'(res_granted * words_eff);
      out_status   <= res_status;
      out_capacity <= capacity_next;
    end
  end

endmodule

// ===== hw/rtl/pfla_checker.sv =====
// ----------------------------------------------------------------------------
// Allocator port checker
// Watches the result stream of the allocator for consistency over time.
// ----------------------------------------------------------------------------
`include "pooled_free_list_allocator_unit_defines.svh"

module pfla_checker
  import pfla_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  logic [INDEX_W-1:0]  granted;
  logic [OFFSET_W-1:0] offset;
  logic                status;
  logic [CAP_W-1:0]    cap;

  assign granted = m_tdata[OFFSET_LSB-1:GRANT_LSB];
  assign offset  = m_tdata[STATUS_LSB-1:OFFSET_LSB];
  assign status  = m_tdata[STATUS_LSB];
  assign cap     = m_tdata[M_USED_W-1:CAP_LSB];

  `PFLA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")
  `PFLA_ASSERT_NOW(a_exhausted_zero, m_tvalid && status == STATUS_EXHAUSTED, granted == '0 && offset == '0, "exhausted beat carries an element")
  `PFLA_ASSERT_NOW(a_granted_in_pool, m_tvalid && status == STATUS_DONE && granted != '0, {1'b0, granted} < cap, "granted element outside the pools")
  `PFLA_ASSERT_NOW(a_cap_range, m_tvalid, cap <= CAP_W'(INDEX_SPACE), "capacity beyond the index space")

endmodule

bind pooled_free_list_allocator_unit pfla_checker u_pfla_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
